[design/vab_pkg.sv]
// Package for the vector angle block: widths, stage counts, constants,
// the side-band type and the arctangent table. No dependencies.
`default_nettype none

package vab_pkg;

  localparam int unsigned IN_W         = 24;  // Q12.12 coordinate
  localparam int unsigned PROD_W       = 48;  // one coordinate product
  localparam int unsigned DOT_W        = 49;  // Q25.24 dot product
  localparam int unsigned ANG_W        = 18;  // Q2.16 angle
  localparam int unsigned SQ_W         = 64;  // sqrt / divide working width
  localparam int unsigned ROOT_W       = 32;  // sqrt result
  localparam int unsigned Q_W          = 31;  // clamped |cosine|, Q1.30
  localparam int unsigned SH_W         = 6;   // normalising shift
  localparam int unsigned NRM_STEPS    = 5;   // shift by 32,16,8,4,2
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XW           = 34;  // CORDIC x/y
  localparam int unsigned TW           = 27;  // CORDIC angle accumulator, Q.24

  localparam logic [Q_W-1:0]       Q_ONE       = Q_W'(31'h4000_0000);
  localparam logic signed [TW-1:0] PI_Q24      = TW'(52707179);
  localparam logic signed [TW-1:0] HALF_PI_Q24 = TW'(26353589);
  localparam logic [ANG_W-1:0]     ANGLE_MAX   = ANG_W'(205887);

  // travels beside the arithmetic through every stage
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic                    zero;
    logic [SH_W-1:0]         sa;
    logic [SH_W-1:0]         sb;
  } vab_side_t;

  // atan(2^-i) in Q.24, rounded
  function automatic logic signed [TW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [TW-1:0] r;
    case (idx)
      5'd0:  r = TW'(13176795);
      5'd1:  r = TW'(7778716);
      5'd2:  r = TW'(4110060);
      5'd3:  r = TW'(2086331);
      5'd4:  r = TW'(1047214);
      5'd5:  r = TW'(524117);
      5'd6:  r = TW'(262123);
      5'd7:  r = TW'(131069);
      5'd8:  r = TW'(65536);
      5'd9:  r = TW'(32768);
      5'd10: r = TW'(16384);
      5'd11: r = TW'(8192);
      5'd12: r = TW'(4096);
      5'd13: r = TW'(2048);
      5'd14: r = TW'(1024);
      5'd15: r = TW'(512);
      5'd16: r = TW'(256);
      5'd17: r = TW'(128);
      5'd18: r = TW'(64);
      5'd19: r = TW'(32);
      5'd20: r = TW'(16);
      5'd21: r = TW'(8);
      5'd22: r = TW'(4);
      5'd23: r = TW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/vab_sqrt_cell.sv]
// One step of the bit-pair integer square root, registered.
// Depends on vab_pkg.
`default_nettype none

module vab_sqrt_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [vab_pkg::SQ_W-1:0] rem_i,
  input  wire logic [vab_pkg::SQ_W-1:0] root_i,
  output logic      [vab_pkg::SQ_W-1:0] rem_o,
  output logic      [vab_pkg::SQ_W-1:0] root_o
);
  import vab_pkg::*;

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (SQ_W - 2 - 2 * Idx);

  logic [SQ_W-1:0] trial;
  logic            take;
  logic [SQ_W-1:0] rem_q, root_q;

  assign trial = root_i + Bit;
  assign take  = (rem_i >= trial);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? (rem_i - trial) : rem_i;
      root_q <= take ? ((root_i >> 1) + Bit) : (root_i >> 1);
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[design/vab_div_cell.sv]
// One quotient bit of the restoring divider, registered; divisor rides along.
// Depends on vab_pkg.
`default_nettype none

module vab_div_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [vab_pkg::SQ_W-1:0]   rem_i,
  input  wire logic [vab_pkg::ROOT_W-1:0] den_i,
  input  wire logic [vab_pkg::ROOT_W-1:0] quo_i,
  output logic      [vab_pkg::SQ_W-1:0]   rem_o,
  output logic      [vab_pkg::ROOT_W-1:0] den_o,
  output logic      [vab_pkg::ROOT_W-1:0] quo_o
);
  import vab_pkg::*;

  localparam int unsigned Sh = DIV_STEPS - 1 - Idx;

  logic [SQ_W-1:0]   dsh;
  logic              take;
  logic [SQ_W-1:0]   rem_q;
  logic [ROOT_W-1:0] den_q, quo_q;

  assign dsh  = SQ_W'(den_i) << Sh;
  assign take = (rem_i >= dsh);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= take ? (rem_i - dsh) : rem_i;
      den_q <= den_i;
      quo_q <= {quo_i[ROOT_W-2:0], take};
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

[design/vab_cordic_cell.sv]
// One CORDIC vectoring micro-rotation with angle accumulation, registered.
// Depends on vab_pkg.
`default_nettype none

module vab_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [vab_pkg::XW-1:0]   x_i,
  input  wire logic signed [vab_pkg::XW-1:0]   y_i,
  input  wire logic signed [vab_pkg::TW-1:0]   t_i,
  output logic signed      [vab_pkg::XW-1:0]   x_o,
  output logic signed      [vab_pkg::XW-1:0]   y_o,
  output logic signed      [vab_pkg::TW-1:0]   t_o
);
  import vab_pkg::*;

  logic signed [XW-1:0] xs, ys;
  logic signed [TW-1:0] at;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [TW-1:0] t_q;

  assign xs = x_i >>> Idx;
  assign ys = y_i >>> Idx;
  assign at = atan_lut(5'(Idx));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[XW-1]) begin
        x_q <= x_i + ys;
        y_q <= y_i - xs;
        t_q <= t_i + at;
      end else begin
        x_q <= x_i - ys;
        y_q <= y_i + xs;
        t_q <= t_i - at;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign t_o = t_q;

endmodule

`default_nettype wire

[design/vector_angle_between_core.sv]
// Top level: angle and exact dot product of two 3D vectors, fully pipelined.
// Depends on vab_pkg, vab_sqrt_cell, vab_div_cell, vab_cordic_cell.
//
// Usage
//   Slave channel s_axis_*: one transfer carries both vectors, six signed
//   Q12.12 coordinates. Master channel m_axis_*: one transfer per input
//   transfer, in order, with the angle (Q2.16 radians), the exact dot
//   product (Q25.24) and, on tuser, the zero-length flag.
//   Throughput: one transfer per cycle unless stalled; the sqrt, divide and CORDIC
//   row advances one stage each cycle and holds up to 131 items in flight.
//   Stalls: the whole row moves together. An output register plus a skid
//   register sit after the last cell; the row and s_axis_tready stop only
//   while the skid register is occupied, so transfers are still taken after the
//   receiver drops tready, until the skid fills. tready is driven from a register.
//   Reset (rst_ni low, asynchronous) empties the row and both output
//   registers; data registers keep whatever they held.
//   Zero-length vectors give angle 0 with the flag set; the dot product is
//   still returned.
`default_nettype none

module vector_angle_between_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: a_x[23:0], a_y[47:24], a_z[71:48], b_x[95:72], b_y[119:96], b_z[143:120]
  input  wire logic [143:0] s_axis_tdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: angle[17:0], dot[66:18], zero padding[71:67]
  output logic      [71:0]  m_axis_tdata_o,
  // tuser: zero_length[0]
  output logic              m_axis_tuser_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i
);
  import vab_pkg::*;

  // stage map
  localparam int unsigned ST_IN  = 0;
  localparam int unsigned ST_MUL = 1;
  localparam int unsigned ST_SUM = 2;
  localparam int unsigned ST_NRM = 3;
  localparam int unsigned ST_SQA = ST_NRM + NRM_STEPS;
  localparam int unsigned ST_DEN = ST_SQA + SQRT_STEPS;
  localparam int unsigned ST_DIV = ST_DEN + 1;
  localparam int unsigned ST_QSQ = ST_DIV + DIV_STEPS;
  localparam int unsigned ST_RAD = ST_QSQ + 1;
  localparam int unsigned ST_SQS = ST_RAD + 1;
  localparam int unsigned ST_COR = ST_SQS + SQRT_STEPS;
  localparam int unsigned NST    = ST_COR + CORDIC_STEPS;
  localparam int unsigned QD_N   = ST_COR - ST_QSQ;

  logic en;
  logic [NST-1:0] v_q;
  vab_side_t side_q [NST];
  vab_side_t side_d [NST];

  // input and product stages
  logic signed [IN_W-1:0]   c_q [6];
  logic signed [PROD_W-1:0] pa_q [3];
  logic signed [PROD_W-1:0] pb_q [3];
  logic signed [PROD_W-1:0] pd_q [3];
  logic [PROD_W-1:0]        asq_q, bsq_q;
  logic signed [DOT_W-1:0]  dot_sum;
  logic [PROD_W-1:0]        asq_sum, bsq_sum;

  // normalisation
  logic [SQ_W-1:0] na_in [NRM_STEPS];
  logic [SQ_W-1:0] nb_in [NRM_STEPS];
  logic [SQ_W-1:0] na_q  [NRM_STEPS];
  logic [SQ_W-1:0] nb_q  [NRM_STEPS];
  logic            na_sh [NRM_STEPS];
  logic            nb_sh [NRM_STEPS];

  // square roots of |a|^2 and |b|^2
  logic [SQ_W-1:0] sqa_rem [SQRT_STEPS];
  logic [SQ_W-1:0] sqa_root[SQRT_STEPS];
  logic [SQ_W-1:0] sqb_rem [SQRT_STEPS];
  logic [SQ_W-1:0] sqb_root[SQRT_STEPS];

  // denominator and numerator
  logic [2*ROOT_W-1:0] den_prod;
  logic [2*ROOT_W-1:0] prod_q;
  logic [SQ_W-1:0]     num_q;
  logic [PROD_W-1:0]   mag;
  logic [SH_W-1:0]     num_sh;
  logic [SH_W:0]       sh_sum;
  vab_side_t           sd_den;

  // divider
  logic [SQ_W-1:0]   dv_rem [DIV_STEPS];
  logic [ROOT_W-1:0] dv_den [DIV_STEPS];
  logic [ROOT_W-1:0] dv_quo [DIV_STEPS];

  // |cosine| clamp, 1 - cos^2, sine root
  logic [ROOT_W-1:0]  q_full;
  logic [Q_W-1:0]     qc;
  logic [2*Q_W-1:0]   qsq_q;
  logic [2*Q_W-1:0]   rad_q;
  logic [Q_W-1:0]     qd_q [QD_N];
  logic [SQ_W-1:0]    sqs_rem [SQRT_STEPS];
  logic [SQ_W-1:0]    sqs_root[SQRT_STEPS];

  // CORDIC
  logic signed [XW-1:0] cx [CORDIC_STEPS];
  logic signed [XW-1:0] cy [CORDIC_STEPS];
  logic signed [TW-1:0] ct [CORDIC_STEPS];

  // final angle and output side
  logic signed [TW-1:0] t_last, t_clamp, t_fin, t_rnd;
  logic [ANG_W-1:0]     ang_last;
  vab_side_t            sd_last;
  logic                 push, pop;
  logic                 out_valid_q, skid_valid_q;
  logic [ANG_W-1:0]     out_ang_q, skid_ang_q;
  logic signed [DOT_W-1:0] out_dot_q, skid_dot_q;
  logic                 out_zero_q, skid_zero_q;

  // ---------------------------------------------------------------- control
  assign en              = ~skid_valid_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  // side-band line
  for (genvar k = 0; k < NST; k++) begin : g_side
    if (k <= ST_MUL) begin : g_pre
      assign side_d[k] = '0;
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        side_d[k]      = '0;
        side_d[k].dot  = dot_sum;
      end
    end else if (k >= ST_NRM && k < ST_SQA) begin : g_nrm
      always_comb begin
        side_d[k] = side_q[k-1];
        if (k == ST_NRM) begin
          side_d[k].zero = (asq_q == '0) || (bsq_q == '0);
        end
        if (na_sh[k-ST_NRM]) begin
          side_d[k].sa = side_q[k-1].sa + SH_W'(64 >> (k - ST_NRM + 1));
        end
        if (nb_sh[k-ST_NRM]) begin
          side_d[k].sb = side_q[k-1].sb + SH_W'(64 >> (k - ST_NRM + 1));
        end
      end
    end else begin : g_pass
      assign side_d[k] = side_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // ------------------------------------------------ input, products, sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        c_q[i] <= s_axis_tdata_i[IN_W*i +: IN_W];
      end
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= c_q[i] * c_q[i];
        pb_q[i] <= c_q[i+3] * c_q[i+3];
        pd_q[i] <= c_q[i] * c_q[i+3];
      end
      asq_q <= asq_sum;
      bsq_q <= bsq_sum;
    end
  end

  assign asq_sum = PROD_W'(pa_q[0]) + PROD_W'(pa_q[1]) + PROD_W'(pa_q[2]);
  assign bsq_sum = PROD_W'(pb_q[0]) + PROD_W'(pb_q[1]) + PROD_W'(pb_q[2]);
  assign dot_sum = DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]);

  // ---------------------------------------------------------- normalise
  // greedy shifts of 32,16,8,4,2 give the least even shift to reach 2^62
  for (genvar j = 0; j < NRM_STEPS; j++) begin : g_nrm
    localparam int unsigned Sh = 64 >> (j + 1);
    if (j == 0) begin : g_first
      assign na_in[j] = SQ_W'(asq_q);
      assign nb_in[j] = SQ_W'(bsq_q);
    end else begin : g_next
      assign na_in[j] = na_q[j-1];
      assign nb_in[j] = nb_q[j-1];
    end
    assign na_sh[j] = (na_in[j][SQ_W-1 -: Sh] == '0);
    assign nb_sh[j] = (nb_in[j][SQ_W-1 -: Sh] == '0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        na_q[j] <= na_sh[j] ? (na_in[j] << Sh) : na_in[j];
        nb_q[j] <= nb_sh[j] ? (nb_in[j] << Sh) : nb_in[j];
      end
    end
  end

  // ------------------------------------------------------ |a| and |b|
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqab
    vab_sqrt_cell #(.Idx(j)) u_sqa (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  ((j == 0) ? na_q[NRM_STEPS-1] : sqa_rem[(j == 0) ? 0 : j-1]),
      .root_i ((j == 0) ? '0 : sqa_root[(j == 0) ? 0 : j-1]),
      .rem_o  (sqa_rem[j]),
      .root_o (sqa_root[j])
    );
    vab_sqrt_cell #(.Idx(j)) u_sqb (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  ((j == 0) ? nb_q[NRM_STEPS-1] : sqb_rem[(j == 0) ? 0 : j-1]),
      .root_i ((j == 0) ? '0 : sqb_root[(j == 0) ? 0 : j-1]),
      .rem_o  (sqb_rem[j]),
      .root_o (sqb_root[j])
    );
  end

  // ------------------------------------- den = |a||b| >> 32, scaled |dot|
  assign sd_den   = side_q[ST_DEN-1];
  assign den_prod = sqa_root[SQRT_STEPS-1][ROOT_W-1:0] * sqb_root[SQRT_STEPS-1][ROOT_W-1:0];
  assign mag      = sd_den.dot[DOT_W-1] ? PROD_W'(-sd_den.dot) : PROD_W'(sd_den.dot);
  assign sh_sum   = (SH_W+1)'(sd_den.sa) + (SH_W+1)'(sd_den.sb);
  assign num_sh   = sh_sum[SH_W:1] - SH_W'(2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= den_prod;
      num_q  <= SQ_W'(mag) << num_sh;
    end
  end

  // ------------------------------------------------------------ divide
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    vab_div_cell #(.Idx(j)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i ((j == 0) ? num_q : dv_rem[(j == 0) ? 0 : j-1]),
      .den_i ((j == 0) ? prod_q[2*ROOT_W-1:ROOT_W] : dv_den[(j == 0) ? 0 : j-1]),
      .quo_i ((j == 0) ? '0 : dv_quo[(j == 0) ? 0 : j-1]),
      .rem_o (dv_rem[j]),
      .den_o (dv_den[j]),
      .quo_o (dv_quo[j])
    );
  end

  // ------------------------------------------- clamp, cos^2, 1 - cos^2
  assign q_full = dv_quo[DIV_STEPS-1];
  assign qc     = (q_full > ROOT_W'(Q_ONE)) ? Q_ONE : q_full[Q_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qsq_q    <= qc * qc;
      rad_q    <= ((2*Q_W)'(1) << 60) - qsq_q;
      qd_q[0]  <= qc;
      for (int i = 1; i < QD_N; i++) begin
        qd_q[i] <= qd_q[i-1];
      end
    end
  end

  // -------------------------------------------------------------- sine
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqs
    vab_sqrt_cell #(.Idx(j)) u_sqs (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  ((j == 0) ? SQ_W'(rad_q) : sqs_rem[(j == 0) ? 0 : j-1]),
      .root_i ((j == 0) ? '0 : sqs_root[(j == 0) ? 0 : j-1]),
      .rem_o  (sqs_rem[j]),
      .root_o (sqs_root[j])
    );
  end

  // ------------------------------------------------------------ CORDIC
  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cor
    vab_cordic_cell #(.Idx(j)) u_cor (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   ((j == 0) ? signed'(XW'(qd_q[QD_N-1])) : cx[(j == 0) ? 0 : j-1]),
      .y_i   ((j == 0) ? signed'(XW'(sqs_root[SQRT_STEPS-1][ROOT_W-1:0]))
                       : cy[(j == 0) ? 0 : j-1]),
      .t_i   ((j == 0) ? TW'(0) : ct[(j == 0) ? 0 : j-1]),
      .x_o   (cx[j]),
      .y_o   (cy[j]),
      .t_o   (ct[j])
    );
  end

  // ------------------------------------------- fold to [0, pi] and round
  assign sd_last  = side_q[NST-1];
  assign t_last   = ct[CORDIC_STEPS-1];
  assign t_clamp  = t_last[TW-1] ? TW'(0) : ((t_last > HALF_PI_Q24) ? HALF_PI_Q24 : t_last);
  assign t_fin    = sd_last.dot[DOT_W-1] ? (PI_Q24 - t_clamp) : t_clamp;
  assign t_rnd    = t_fin + TW'(128);
  assign ang_last = sd_last.zero ? '0 : t_rnd[ANG_W+7:8];

  // ------------------------------------------------ output and skid regs
  assign push = en & v_q[NST-1];
  assign pop  = out_valid_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_ang_q  <= skid_ang_q;
        out_dot_q  <= skid_dot_q;
        out_zero_q <= skid_zero_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_ang_q  <= ang_last;
        skid_dot_q  <= sd_last.dot;
        skid_zero_q <= sd_last.zero;
      end else begin
        out_ang_q  <= ang_last;
        out_dot_q  <= sd_last.dot;
        out_zero_q <= sd_last.zero;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_dot_q, out_ang_q};
  assign m_axis_tuser_o  = out_zero_q;

  // -------------------------------------------------------- assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transfer while output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready_i) |=> skid_valid_q)
    else $error("skid transfer lost during stall");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_zero_q) |-> (out_ang_q == '0))
    else $error("zero-length result with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ang_q <= ANGLE_MAX))
    else $error("angle beyond pi");

endmodule

`default_nettype wire

[dv/vector_angle_between_core_tb.sv]
// Testbench for vector_angle_between_core: random and directed vector pairs,
// checked against a bit-exact angle/dot predictor. Depends on the RTL only.
`default_nettype none

module vector_angle_between_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [17:0] angle;
    logic [48:0] dot;
    logic        zero;
  } angle_res_t;

  // predicts angle and dot for each pair taken in, checks results in order
  class angle_scoreboard;
    angle_res_t expected_q[$];
    int unsigned errors;

    static function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    static function bit [63:0] norm(bit [63:0] v, output int unsigned s);
      s = 0;
      while (v < (64'h1 << 62)) begin
        v = v << 2;
        s += 2;
      end
      return v;
    endfunction

    function void note_pair(logic [143:0] d);
      longint c[6];
      longint asq, bsq, dot, x, y, t, xs, ys;
      bit [63:0] ma, mb, den, mag, num, q;
      int unsigned sa, sb;
      angle_res_t r;
      for (int i = 0; i < 6; i++) c[i] = longint'($signed(d[i*24 +: 24]));
      asq = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      bsq = c[3]*c[3] + c[4]*c[4] + c[5]*c[5];
      dot = c[0]*c[3] + c[1]*c[4] + c[2]*c[5];
      r.dot = dot[48:0];
      r.angle = '0;
      r.zero = 1'b0;
      if (asq == 0 || bsq == 0) begin
        r.zero = 1'b1;
      end else begin
        ma = isqrt(norm(asq, sa));
        mb = isqrt(norm(bsq, sb));
        den = (ma * mb) >> 32;
        mag = dot < 0 ? 64'(-dot) : 64'(dot);
        num = mag << ((sa + sb) / 2 - 2);
        q = num / den;
        if (q > (64'h1 << 30)) q = 64'h1 << 30;
        x = longint'(q);
        y = longint'(isqrt((64'h1 << 60) - q * q));
        t = 0;
        for (int i = 0; i < 24; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            t += longint'(vab_pkg::atan_lut(i[4:0]));
          end else begin
            x = x - ys;
            y = y + xs;
            t -= longint'(vab_pkg::atan_lut(i[4:0]));
          end
        end
        if (t < 0) t = 0;
        if (t > 26353589) t = 26353589;
        if (dot < 0) t = 52707179 - t;
        t = (t + 128) >> 8;
        r.angle = t[17:0];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(angle_res_t act);
      angle_res_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result angle=%0d dot=%h zero=%b", $time,
                 act.angle, act.dot, act.zero);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.angle !== exp_r.angle) begin
        $display("%0t: angle expected %0d actual %0d", $time, exp_r.angle, act.angle);
        errors++;
      end
      if (act.dot !== exp_r.dot) begin
        $display("%0t: dot expected %h actual %h", $time, exp_r.dot, act.dot);
        errors++;
      end
      if (act.zero !== exp_r.zero) begin
        $display("%0t: zero_length expected %b actual %b", $time, exp_r.zero, act.zero);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [143:0] s_data = '0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [71:0]  m_data;
  logic         m_user;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic         hold_req = 1'b0;   // asks the receiver for a long hold-off
  int unsigned  cycles = 0;

  angle_scoreboard sb = new();

  vector_angle_between_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // outputs are stable between the edges, so sample at the falling edge
  always @(negedge clk) begin
    if (rst_n && m_valid && m_ready)
      sb.check_result('{angle: m_data[17:0], dot: m_data[66:18], zero: m_user});
  end

  // receiver: stall pattern changes every window; a long hold-off on request
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 80)) begin
        @(posedge clk);
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= ($urandom_range(0, 1) == 1);
          2: m_ready <= ($urandom_range(0, 4) == 0);
          default: m_ready <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  function automatic logic [143:0] pack(int ax, int ay, int az, int bx, int by, int bz);
    return {24'(bz), 24'(by), 24'(bx), 24'(az), 24'(ay), 24'(ax)};
  endfunction

  // one transfer; tvalid is held low first for the given gap
  task automatic send_pair(logic [143:0] d, int unsigned gap);
    bit hit;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    do begin
      @(negedge clk);
      hit = s_ready;
      @(posedge clk);
    end while (!hit);
    sb.note_pair(d);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic int small_c();
    return $urandom_range(0, 2000) - 1000;
  endfunction

  function automatic logic [143:0] random_pair();
    int kind, ax, ay, az, k;
    logic [143:0] d;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: d = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      3, 4: d = pack(small_c(), small_c(), small_c(), small_c(), small_c(), small_c());
      5, 6: begin
        // near parallel or antiparallel: |cosine| near one
        ax = $urandom_range(0, 4000000) - 2000000;
        ay = $urandom_range(0, 4000000) - 2000000;
        az = $urandom_range(0, 4000000) - 2000000;
        k = $urandom_range(0, 1) ? 1 : -2;
        d = pack(ax, ay, az, k*ax + $urandom_range(0, 4) - 2, k*ay,
                 k*az + $urandom_range(0, 2) - 1);
      end
      7: begin
        // orthogonal
        ax = $urandom_range(0, 8000000) - 4000000;
        ay = $urandom_range(0, 8000000) - 4000000;
        d = pack(ax, ay, small_c(), -ay, ax, 0);
      end
      default: begin
        d = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        if ($urandom_range(0, 1)) d[71:0] = '0;
        else d[143:72] = '0;
      end
    endcase
    return d;
  endfunction

  initial begin
    int unsigned gap;
    int unsigned burst;
    bit          held;
    bit          drained;
    held = 1'b0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes, zero vectors, parallel, antiparallel, orthogonal
    send_pair(pack(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608), 0);
    send_pair(pack(8388607, 8388607, 8388607, -8388608, -8388608, -8388608), 0);
    send_pair(pack(8388607, 8388607, 8388607, 8388607, 8388607, 8388607), 0);
    send_pair(pack(0, 0, 0, 5, -7, 9), 0);
    send_pair(pack(5, -7, 9, 0, 0, 0), 1);
    send_pair(pack(0, 0, 0, 0, 0, 0), 0);
    send_pair(pack(1, 0, 0, 0, 1, 0), 0);
    send_pair(pack(8388607, 0, 0, 0, -8388608, 0), 2);
    send_pair(pack(1, 1, 1, -1, -1, -1), 0);
    send_pair(pack(3, 4, 0, 6, 8, 0), 0);
    send_pair(pack(1, 0, 0, 1, 0, 0), 0);
    send_pair(pack(-1, 0, 0, 8388607, 0, 0), 0);
    send_pair(pack(8388607, -8388608, 8388607, -8388608, 8388607, -8388608), 0);
    send_pair(pack(0, 0, 1, 0, 0, -8388608), 3);
    send_pair(pack(4096, 4096, 0, 4096, 0, 0), 0);
    send_pair(pack(0, 8388607, 0, 0, 8388607, 1), 0);
    send_pair(pack(-8388608, 0, 0, 0, 0, 0), 0);
    send_pair(pack(1, 2, 3, -3, 0, 1), 0);
    send_pair({144{1'b1}}, 0);
    send_pair(pack(2, 1, 0, 2, 1, 1), 0);
    s_valid <= 1'b0;
    @(posedge clk);
    drain();

    // random part: bursts with gaps, one long receiver hold-off, one drain pause
    for (int n = 0; n < 450; ) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (n >= 150 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (n >= 300 && !drained) begin
        drained = 1'b1;
        s_valid <= 1'b0;
        @(posedge clk);
        drain();
      end
      for (int j = 0; j < burst && n < 450; j++, n++)
        send_pair(random_pair(), j == 0 ? gap : 0);
    end
    s_valid <= 1'b0;
    @(posedge clk);
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
